>>> rtl/uat_pkg.sv
package uat_pkg;

    // Field widths
    localparam int VAL_W   = 32;
    localparam int REQ_W   = 3;
    localparam int STS_W   = 2;
    localparam int POS_W   = 4;
    localparam int MCNT_W  = 5;

    // Default table depth
    localparam int UAT_DEPTH = 16;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd1;
    localparam logic [REQ_W-1:0] REQ_UPDATE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SHOW   = 3'd4;

    // Result status codes
    localparam logic [STS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STS_W-1:0] ST_EMPTY     = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // latch a new transaction
        logic single;   // produce the one result of an add or empty-table request
        logic scan;     // walk the stored entries
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic req_ok;      // request code on the port is a known one
        logic req_add;     // request code on the port is add
        logic count_zero;  // table holds no entries
        logic scan_end;    // every stored entry has been evaluated
    } dp_sts_t;

endpackage

>>> rtl/uat_ctrl.sv
module uat_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  uat_pkg::dp_sts_t   sts,
    output uat_pkg::ctl_cmd_t  cmd,
    output logic               busy
);
    import uat_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SINGLE = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign busy = (state_reg != S_IDLE);

    // Decode the next state and the commands of this cycle
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start && sts.req_ok)
                begin
                    cmd.load = 1'b1;
                    if (sts.req_add || sts.count_zero)
                        state_next = S_SINGLE;
                    else
                        state_next = S_SCAN;
                end
            end
            S_SINGLE:
            begin
                cmd.single = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_end)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/uat_datapath.sv
module uat_datapath #(
    parameter int DEPTH = uat_pkg::UAT_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  uat_pkg::ctl_cmd_t                 cmd,
    output uat_pkg::dp_sts_t                  sts,
    input  logic [uat_pkg::REQ_W-1:0]         req_type,
    input  logic signed [uat_pkg::VAL_W-1:0]  key,
    input  logic signed [uat_pkg::VAL_W-1:0]  new_value,
    output logic                              valid,
    output logic [uat_pkg::STS_W-1:0]         status,
    output logic signed [uat_pkg::VAL_W-1:0]  value,
    output logic [uat_pkg::POS_W-1:0]         position,
    output logic [uat_pkg::MCNT_W-1:0]        match_count,
    output logic                              last
);
    import uat_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Entry store
    logic [VAL_W-1:0] mem [DEPTH];
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [VAL_W-1:0] mem_wd;
    logic             rd_en;
    logic [VAL_W-1:0] rd_data_reg;

    // Transaction registers
    logic [REQ_W-1:0] req_reg;
    logic [VAL_W-1:0] key_reg;
    logic [VAL_W-1:0] nv_reg;

    // Table and scan state
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic          stg_vld_reg, stg_vld_next;
    logic [AW-1:0] stg_idx_reg;
    logic [CW-1:0] hits_reg, hits_next;
    logic [AW-1:0] first_reg, first_next;
    logic          pend_vld_reg, pend_vld_next;
    logic [AW-1:0] pend_idx_reg, pend_idx_next;

    // Result staging
    logic             res_vld;
    logic [STS_W-1:0] res_sts;
    logic [VAL_W-1:0] res_val;
    logic [AW-1:0]    res_pos;
    logic [CW-1:0]    res_cnt;
    logic             res_last;
    logic [AW+POS_W-1:0]  pos_ext;
    logic [CW+MCNT_W-1:0] cnt_ext;

    logic          full;
    logic          match;
    logic          scan_end;
    logic [CW-1:0] stg_idx_ext;

    assign full        = (count_reg == CW'(DEPTH));
    assign match       = (rd_data_reg == key_reg);
    assign scan_end    = (ptr_reg == count_reg) && !stg_vld_reg;
    assign stg_idx_ext = CW'(stg_idx_reg);
    assign rd_en       = cmd.scan && (ptr_reg < count_reg);

    assign sts.req_ok     = (req_type <= REQ_SHOW);
    assign sts.req_add    = (req_type == REQ_ADD);
    assign sts.count_zero = (count_reg == '0);
    assign sts.scan_end   = scan_end;

    // Work out writes, scan progress and the result of this cycle
    always_comb
    begin
        mem_we        = 1'b0;
        mem_wa        = count_reg[AW-1:0];
        mem_wd        = key_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        stg_vld_next  = 1'b0;
        hits_next     = hits_reg;
        first_next    = first_reg;
        pend_vld_next = pend_vld_reg;
        pend_idx_next = pend_idx_reg;
        res_vld       = 1'b0;
        res_sts       = ST_OK;
        res_val       = key_reg;
        res_pos       = '0;
        res_cnt       = count_reg;
        res_last      = 1'b1;

        if (cmd.load)
        begin
            ptr_next      = '0;
            hits_next     = '0;
            first_next    = '0;
            pend_vld_next = 1'b0;
        end

        if (cmd.single)
        begin
            res_vld = 1'b1;
            if (req_reg == REQ_ADD)
            begin
                if (full)
                begin
                    res_sts = ST_FULL;
                end
                else
                begin
                    mem_we     = 1'b1;
                    res_pos    = count_reg[AW-1:0];
                    res_cnt    = count_reg + CW'(1);
                    count_next = count_reg + CW'(1);
                end
            end
            else
            begin
                res_sts = ST_EMPTY;
                res_val = '0;
                res_cnt = '0;
            end
        end

        // Issue the next read
        if (rd_en)
        begin
            ptr_next     = ptr_reg + CW'(1);
            stg_vld_next = 1'b1;
        end

        // Evaluate the entry read last cycle
        if (cmd.scan && stg_vld_reg)
        begin
            case (req_reg)
                REQ_SEARCH:
                begin
                    if (match)
                    begin
                        res_vld       = pend_vld_reg;
                        res_pos       = pend_idx_reg;
                        res_last      = 1'b0;
                        pend_vld_next = 1'b1;
                        pend_idx_next = stg_idx_reg;
                    end
                end
                REQ_UPDATE:
                begin
                    if (match)
                    begin
                        mem_we    = 1'b1;
                        mem_wa    = stg_idx_reg;
                        mem_wd    = nv_reg;
                        hits_next = hits_reg + CW'(1);
                        if (hits_reg == '0)
                            first_next = stg_idx_reg;
                    end
                end
                REQ_DELETE:
                begin
                    if (hits_reg != '0)
                    begin
                        // move later entries one place toward the front
                        mem_we = 1'b1;
                        mem_wa = stg_idx_reg - AW'(1);
                        mem_wd = rd_data_reg;
                    end
                    else if (match)
                    begin
                        hits_next  = CW'(1);
                        first_next = stg_idx_reg;
                    end
                end
                REQ_SHOW:
                begin
                    res_vld  = 1'b1;
                    res_val  = rd_data_reg;
                    res_pos  = stg_idx_reg;
                    res_last = ((stg_idx_ext + CW'(1)) == count_reg);
                end
                default:
                begin
                end
            endcase
        end

        // Close the scan
        if (cmd.scan && scan_end)
        begin
            case (req_reg)
                REQ_SEARCH:
                begin
                    res_vld = 1'b1;
                    if (pend_vld_reg)
                        res_pos = pend_idx_reg;
                    else
                        res_sts = ST_NOT_FOUND;
                end
                REQ_UPDATE:
                begin
                    res_vld = 1'b1;
                    if (hits_reg == '0)
                    begin
                        res_sts = ST_NOT_FOUND;
                        res_cnt = '0;
                    end
                    else
                    begin
                        res_val = nv_reg;
                        res_pos = first_reg;
                        res_cnt = hits_reg;
                    end
                end
                REQ_DELETE:
                begin
                    res_vld = 1'b1;
                    if (hits_reg == '0)
                    begin
                        res_sts = ST_NOT_FOUND;
                    end
                    else
                    begin
                        res_pos    = first_reg;
                        res_cnt    = count_reg - CW'(1);
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign pos_ext = {{POS_W{1'b0}}, res_pos};
    assign cnt_ext = {{MCNT_W{1'b0}}, res_cnt};

    // Write and read the entry store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (rd_en)
        begin
            rd_data_reg <= mem[ptr_reg[AW-1:0]];
            stg_idx_reg <= ptr_reg[AW-1:0];
        end
    end

    // Latch the transaction and the result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_type;
            key_reg <= key;
            nv_reg  <= new_value;
        end
        if (res_vld)
        begin
            status      <= res_sts;
            value       <= res_val;
            position    <= pos_ext[POS_W-1:0];
            match_count <= cnt_ext[MCNT_W-1:0];
            last        <= res_last;
        end
        ptr_reg      <= ptr_next;
        hits_reg     <= hits_next;
        first_reg    <= first_next;
        pend_idx_reg <= pend_idx_next;
    end

    // Advance the control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            stg_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
            valid        <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            stg_vld_reg  <= stg_vld_next;
            pend_vld_reg <= pend_vld_next;
            valid        <= res_vld;
        end
    end

endmodule

>>> rtl/unsorted_array_table.sv
// Channel   Ports                                       Transaction
// --------  ------------------------------------------  ---------------------------
// request   start, busy, req_type, key, new_value       start high and busy low
// result    valid, status, value, position,             valid high, one cycle each
//           match_count, last
//
// Add, and any request on an empty table, keeps busy high for the S_SINGLE state.
// Search, update, delete and show keep busy high while the single read port of
// the entry store walks one entry a cycle, each checked from a registered read,
// and then while a closing step ends the request.
// Unknown request codes are taken and dropped with busy staying low.
// Reset clears the entry count and the controller; the result side cannot stall.
module unsorted_array_table #(
    parameter int DEPTH = uat_pkg::UAT_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [uat_pkg::REQ_W-1:0]         req_type,
    input  logic signed [uat_pkg::VAL_W-1:0]  key,
    input  logic signed [uat_pkg::VAL_W-1:0]  new_value,
    output logic                              valid,
    output logic [uat_pkg::STS_W-1:0]         status,
    output logic signed [uat_pkg::VAL_W-1:0]  value,
    output logic [uat_pkg::POS_W-1:0]         position,
    output logic [uat_pkg::MCNT_W-1:0]        match_count,
    output logic                              last
);
    import uat_pkg::*;

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    // Sequence each transaction
    uat_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Hold the table and build the results
    uat_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (req_type),
        .key         (key),
        .new_value   (new_value),
        .valid       (valid),
        .status      (status),
        .value       (value),
        .position    (position),
        .match_count (match_count),
        .last        (last)
    );

endmodule

>>> test/unsorted_array_table_tb.sv
module unsorted_array_table_tb;

    import uat_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int SETTLE_CYCLES  = UAT_DEPTH + 8;
    localparam int PHASE_ITEMS    = 120;
    localparam int MODE_ITEMS     = 35;
    localparam logic [REQ_W-1:0] REQ_FIRST_UNUSED = REQ_SHOW + 3'd1;
    localparam logic [REQ_W-1:0] REQ_LAST_CODE    = '1;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [VAL_W-1:0]  value;
        logic [POS_W-1:0]  position;
        logic [MCNT_W-1:0] match_count;
        logic              last;
    } table_result_t;

    // Tracks the table contents and the results each request should produce
    class table_tracker;
        logic [VAL_W-1:0] entries [UAT_DEPTH];
        int unsigned      count;
        table_result_t    pending_results [$];
        int unsigned      errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function void push(logic [STS_W-1:0] st, logic [VAL_W-1:0] val, int unsigned pos,
                           int unsigned cnt, logic fin);
            table_result_t r;
            r.status      = st;
            r.value       = val;
            r.position    = pos[POS_W-1:0];
            r.match_count = cnt[MCNT_W-1:0];
            r.last        = fin;
            pending_results.push_back(r);
        endfunction

        // Work out the results of one accepted transaction and update the table
        function void take_request(logic [REQ_W-1:0] req, logic [VAL_W-1:0] k,
                                   logic [VAL_W-1:0] nv);
            int unsigned hits;
            int unsigned n;
            int unsigned first;
            int          hit_at;
            logic [VAL_W-1:0] gone;
            hits   = 0;
            n      = 0;
            first  = 0;
            hit_at = -1;
            if (req > REQ_SHOW)
                return;
            if (req == REQ_ADD)
            begin
                if (count >= UAT_DEPTH)
                    push(ST_FULL, k, 0, count, 1'b1);
                else
                begin
                    entries[count] = k;
                    count++;
                    push(ST_OK, k, count - 1, count, 1'b1);
                end
                return;
            end
            if (count == 0)
            begin
                push(ST_EMPTY, '0, 0, 0, 1'b1);
                return;
            end
            case (req)
                REQ_SEARCH:
                begin
                    for (int j = 0; j < count; j++)
                        if (entries[j] == k)
                            hits++;
                    if (hits == 0)
                        push(ST_NOT_FOUND, k, 0, count, 1'b1);
                    for (int j = 0; j < count; j++)
                        if (entries[j] == k)
                        begin
                            n++;
                            push(ST_OK, entries[j], j, count, n == hits);
                        end
                end
                REQ_UPDATE:
                begin
                    for (int j = 0; j < count; j++)
                        if (entries[j] == k)
                        begin
                            if (hits == 0)
                                first = j;
                            entries[j] = nv;
                            hits++;
                        end
                    if (hits == 0)
                        push(ST_NOT_FOUND, k, 0, 0, 1'b1);
                    else
                        push(ST_OK, nv, first, hits, 1'b1);
                end
                REQ_DELETE:
                begin
                    for (int j = 0; j < count; j++)
                        if (hit_at < 0 && entries[j] == k)
                            hit_at = j;
                    if (hit_at < 0)
                        push(ST_NOT_FOUND, k, 0, count, 1'b1);
                    else
                    begin
                        gone = entries[hit_at];
                        for (int j = hit_at; j + 1 < count; j++)
                            entries[j] = entries[j + 1];
                        count--;
                        push(ST_OK, gone, hit_at, count, 1'b1);
                    end
                end
                default:
                begin
                    for (int j = 0; j < count; j++)
                        push(ST_OK, entries[j], j, count, j + 1 == count);
                end
            endcase
        endfunction

        // Compare one result transaction with the oldest one outstanding
        function void check_result(table_result_t got);
            table_result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: status %0d value %h position %0d",
                         $time, got.status, got.value, got.position);
                $display("%0t: unexpected result: count %0d last %0d",
                         $time, got.match_count, got.last);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.value !== want.value)
            begin
                $display("%0t: value expected %h actual %h", $time, want.value, got.value);
                errors++;
            end
            if (got.position !== want.position)
            begin
                $display("%0t: position expected %0d actual %0d", $time, want.position,
                         got.position);
                errors++;
            end
            if (got.match_count !== want.match_count)
            begin
                $display("%0t: match_count expected %0d actual %0d", $time, want.match_count,
                         got.match_count);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
                errors++;
            end
        endfunction

        function bit drained();
            return pending_results.size() == 0;
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [REQ_W-1:0]         req_type;
    logic signed [VAL_W-1:0]  key;
    logic signed [VAL_W-1:0]  new_value;
    logic                     valid;
    logic [STS_W-1:0]         status;
    logic signed [VAL_W-1:0]  value;
    logic [POS_W-1:0]         position;
    logic [MCNT_W-1:0]        match_count;
    logic                     last;

    table_tracker tracker;
    int unsigned  cycle_count = 0;
    int unsigned  idle_pct    = 0;

    unsorted_array_table u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .key         (key),
        .new_value   (new_value),
        .valid       (valid),
        .status      (status),
        .value       (value),
        .position    (position),
        .match_count (match_count),
        .last        (last)
    );

    always #10 clk = ~clk;

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Check results first: a result in the accepting cycle belongs to an older transaction
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (valid === 1'b1)
                tracker.check_result({status, value, position, match_count, last});
            if (start && busy === 1'b0)
                tracker.take_request(req_type, key, new_value);
        end
    end

    // Present one request, idling first at random, and hold it until taken
    task automatic send_request(logic [REQ_W-1:0] req, logic [VAL_W-1:0] k,
                                logic [VAL_W-1:0] nv);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start     <= 1'b0;
            key       <= $urandom;
            new_value <= $urandom;
            @(negedge clk);
        end
        start     <= 1'b1;
        req_type  <= req;
        key       <= k;
        new_value <= nv;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        @(negedge clk);
    endtask

    // Hold off until every outstanding result has arrived and the block has settled
    task automatic drain_results();
        start <= 1'b0;
        while (!tracker.drained())
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [VAL_W-1:0] extreme_value();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    // Prefer stored values so that searches, updates and deletes mostly hit
    function automatic logic [VAL_W-1:0] pick_key(int unsigned hit_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < hit_pct && tracker.count > 0)
            return tracker.entries[$urandom_range(0, tracker.count - 1)];
        else if (r < hit_pct + 15)
            return $urandom_range(0, 3);
        else if (r < hit_pct + 25)
            return extreme_value();
        return $urandom;
    endfunction

    function automatic logic [VAL_W-1:0] pick_add_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom_range(0, 3);
        else if (r < 50)
            return extreme_value();
        return $urandom;
    endfunction

    // Alternate filling and draining stretches so both full and empty tables occur
    task automatic random_request(bit filling);
        int unsigned      r;
        logic [VAL_W-1:0] nv;
        r  = $urandom_range(0, 99);
        nv = ($urandom_range(0, 99) < 30) ? $urandom_range(0, 3) : $urandom;
        if (filling)
        begin
            if (r < 60)
                send_request(REQ_ADD, pick_add_value(), $urandom);
            else if (r < 70)
                send_request(REQ_SEARCH, pick_key(65), $urandom);
            else if (r < 80)
                send_request(REQ_UPDATE, pick_key(65), nv);
            else if (r < 87)
                send_request(REQ_DELETE, pick_key(65), $urandom);
            else if (r < 95)
                send_request(REQ_SHOW, $urandom, $urandom);
            else
                send_request(REQ_W'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_CODE)),
                             $urandom, $urandom);
        end
        else
        begin
            if (r < 15)
                send_request(REQ_ADD, pick_add_value(), $urandom);
            else if (r < 25)
                send_request(REQ_SEARCH, pick_key(65), $urandom);
            else if (r < 35)
                send_request(REQ_UPDATE, pick_key(65), nv);
            else if (r < 85)
                send_request(REQ_DELETE, pick_key(75), $urandom);
            else if (r < 95)
                send_request(REQ_SHOW, $urandom, $urandom);
            else
                send_request(REQ_W'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_CODE)),
                             $urandom, $urandom);
        end
    endtask

    initial
    begin
        int unsigned phase_idle [3];
        phase_idle = '{36, 45, 0};
        tracker    = new();
        rst_n      = 1'b0;
        start      = 1'b0;
        req_type   = REQ_ADD;
        key        = '0;
        new_value  = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Requests on an empty table, then unused codes
        send_request(REQ_SEARCH, 32'h0000_0001, 32'h0);
        send_request(REQ_UPDATE, 32'h0000_0001, 32'hffff_ffff);
        send_request(REQ_DELETE, 32'h0000_0001, 32'h0);
        send_request(REQ_SHOW, 32'hffff_ffff, 32'hffff_ffff);
        send_request(REQ_FIRST_UNUSED, 32'h8000_0000, 32'h7fff_ffff);
        send_request(REQ_FIRST_UNUSED + 3'd1, 32'h7fff_ffff, 32'h8000_0000);
        send_request(REQ_LAST_CODE, 32'hffff_ffff, 32'hffff_ffff);
        // Extreme values, with a duplicate
        send_request(REQ_ADD, 32'h8000_0000, 32'h0);
        send_request(REQ_ADD, 32'h7fff_ffff, 32'h0);
        send_request(REQ_ADD, 32'h0000_0000, 32'h0);
        send_request(REQ_ADD, 32'hffff_ffff, 32'h0);
        send_request(REQ_ADD, 32'hffff_ffff, 32'h0);
        // Multiple matches, misses, delete with shift
        send_request(REQ_SEARCH, 32'hffff_ffff, 32'h0);
        send_request(REQ_UPDATE, 32'hffff_ffff, 32'h8000_0000);
        send_request(REQ_SEARCH, 32'h8000_0000, 32'h0);
        send_request(REQ_SEARCH, 32'h0001_2345, 32'h0);
        send_request(REQ_UPDATE, 32'h0001_2345, 32'h5555_aaaa);
        send_request(REQ_DELETE, 32'h8000_0000, 32'h0);
        send_request(REQ_DELETE, 32'h0000_0005, 32'h0);
        send_request(REQ_SHOW, 32'h0, 32'h0);
        drain_results();

        // Random phases: sender idles often, then more often, then never
        for (int p = 0; p < 3; p++)
        begin
            idle_pct = phase_idle[p];
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_request((i / MODE_ITEMS) % 2 == 0);
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.drained())
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
